// ===== hw/rtl/i2c_master_phase_sequencer_core_defines.svh =====
// Assertion macros used by the checker file of the I2C phase sequencer.
`ifndef I2C_MASTER_PHASE_SEQUENCER_CORE_DEFINES_SVH
`define I2C_MASTER_PHASE_SEQUENCER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define I2CMPS_ASSERT_NOW(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("%m: check failed");

// Next-cycle implication, disabled while reset is asserted.
`define I2CMPS_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("%m: check failed");

`endif

// ===== hw/rtl/i2cmps_pkg.sv =====
// Types and constants of the I2C master phase sequencer.
package i2cmps_pkg;

	typedef enum logic [2:0] {
		OP_START = 3'd0,
		OP_STOP  = 3'd1,
		OP_WRITE = 3'd2,
		OP_READ  = 3'd3,
		OP_SACK  = 3'd4,
		OP_RACK  = 3'd5
	} op_t;

	// Position inside a three-phase bit slot.
	localparam logic [1:0] SUB_FIRST = 2'd0;
	localparam logic [1:0] SUB_MID   = 2'd1;
	localparam logic [1:0] SUB_LAST  = 2'd2;

	localparam logic [15:0] PHASE_TICKS_RESET = 16'd720;

	typedef struct packed {
		logic       cmd_valid;
		logic [2:0] opcode;
		logic [7:0] tx_byte;
		logic       ack_to_send;
		logic       sda_in;
	} cmd_t;

	typedef struct packed {
		logic       scl_level;
		logic       sda_level;
		logic       busy_res;
		logic       done_res;
		logic [7:0] rx_byte;
		logic       ack_seen;
	} res_t;

	function automatic logic [4:0] last_phase(input op_t op);
		logic [4:0] lp;
		case (op)
			OP_START: lp = 5'd3;
			OP_STOP:  lp = 5'd2;
			OP_WRITE: lp = 5'd23;
			OP_READ:  lp = 5'd24;
			OP_SACK:  lp = 5'd2;
			default:  lp = 5'd3;
		endcase
		return lp;
	endfunction

endpackage

// ===== hw/rtl/i2cmps_if.sv =====
// Handshake channel interfaces: command tick, result, and phase length write.
interface i2cmps_cmd_if ();
	logic       valid;
	logic       ready;
	logic       cmd_valid;
	logic [2:0] opcode;
	logic [7:0] tx_byte;
	logic       ack_to_send;
	logic       sda_in;

	modport source (output valid, cmd_valid, opcode, tx_byte, ack_to_send, sda_in,
		input ready);
	modport sink (input valid, cmd_valid, opcode, tx_byte, ack_to_send, sda_in,
		output ready);
endinterface

interface i2cmps_res_if ();
	logic       valid;
	logic       ready;
	logic       scl_level;
	logic       sda_level;
	logic       busy_res;
	logic       done_res;
	logic [7:0] rx_byte;
	logic       ack_seen;

	modport source (output valid, scl_level, sda_level, busy_res, done_res, rx_byte,
		ack_seen, input ready);
	modport sink (input valid, scl_level, sda_level, busy_res, done_res, rx_byte,
		ack_seen, output ready);
endinterface

interface i2cmps_cfg_if ();
	logic        valid;
	logic        ready;
	logic [15:0] phase_ticks;

	modport source (output valid, phase_ticks, input ready);
	modport sink (input valid, phase_ticks, output ready);
endinterface

// ===== hw/rtl/i2cmps_seq.sv =====
// Phase sequencer state: tick counter, phase/bit position, shifters and bus drives.
module i2cmps_seq import i2cmps_pkg::*; #(
	parameter int COUNTER_WIDTH = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     step,
	input  cmd_t                     item,
	input  logic [COUNTER_WIDTH-1:0] phase_lim,
	output res_t                     result
);

	logic [COUNTER_WIDTH-1:0] tick_q, n_tick;
	logic [COUNTER_WIDTH:0]   tick_inc;
	logic [4:0]               phase_q, n_phase;
	op_t                      cmd_q, n_cmd;
	logic [7:0]               send_q, n_send;
	logic [7:0]               rx_q, n_rx;
	logic                     scl_q, n_scl;
	logic                     sda_q, n_sda;
	logic                     run_q, n_run;
	logic                     ack_q, n_ack;
	logic [1:0]               sub_q, n_sub;
	logic [2:0]               bit_q, n_bit;
	logic                     done;
	logic                     apply;

	always_comb begin
		n_tick  = tick_q;
		n_phase = phase_q;
		n_cmd   = cmd_q;
		n_send  = send_q;
		n_rx    = rx_q;
		n_scl   = scl_q;
		n_sda   = sda_q;
		n_run   = run_q;
		n_ack   = ack_q;
		n_sub   = sub_q;
		n_bit   = bit_q;
		done    = 1'b0;
		apply   = 1'b0;
		tick_inc = {1'b0, tick_q} + (COUNTER_WIDTH+1)'(1);

		if (step) begin
			if (run_q) begin
				if (tick_inc >= {1'b0, phase_lim}) begin
					n_tick = '0;
					if (phase_q >= last_phase(cmd_q)) begin
						n_run   = 1'b0;
						n_phase = 5'd0;
						done    = 1'b1;
					end else begin
						n_phase = phase_q + 5'd1;
						apply   = 1'b1;
						// read byte: the release phase precedes the first bit slot
						if (cmd_q == OP_READ && phase_q == 5'd0) begin
							n_sub = SUB_FIRST;
							n_bit = 3'd0;
						end else if (sub_q == SUB_LAST) begin
							n_sub = SUB_FIRST;
							n_bit = bit_q + 3'd1;
						end else begin
							n_sub = sub_q + 2'd1;
						end
					end
				end else begin
					n_tick = tick_inc[COUNTER_WIDTH-1:0];
				end
			end else if (item.cmd_valid && item.opcode <= 3'(OP_RACK)) begin
				n_cmd   = op_t'(item.opcode);
				n_run   = 1'b1;
				n_phase = 5'd0;
				n_tick  = '0;
				n_sub   = SUB_FIRST;
				n_bit   = 3'd0;
				apply   = 1'b1;
				case (n_cmd)
					OP_WRITE: n_send = item.tx_byte;
					OP_SACK:  n_send = {7'd0, item.ack_to_send};
					OP_READ:  n_rx   = 8'd0;
					default:  ;
				endcase
			end
		end

		if (apply) begin
			case (n_cmd)
				OP_START: begin
					if (n_phase == 5'd0)      n_sda = 1'b1;
					else if (n_phase == 5'd1) n_scl = 1'b1;
					else if (n_phase == 5'd2) n_sda = 1'b0;
					else                      n_scl = 1'b0;
				end
				OP_STOP: begin
					if (n_phase == 5'd0)      n_sda = 1'b0;
					else if (n_phase == 5'd1) n_scl = 1'b1;
					else                      n_sda = 1'b1;
				end
				OP_WRITE: begin
					if (n_sub == SUB_FIRST)    n_sda = n_send[3'd7 - n_bit];
					else if (n_sub == SUB_MID) n_scl = 1'b1;
					else                       n_scl = 1'b0;
				end
				OP_READ: begin
					if (n_phase == 5'd0)            n_sda = 1'b1;
					else if (n_sub == SUB_FIRST)    n_scl = 1'b1;
					else if (n_sub == SUB_MID) begin
						if (item.sda_in) n_rx[3'd7 - n_bit] = 1'b1;
					end else                        n_scl = 1'b0;
				end
				OP_SACK: begin
					if (n_phase == 5'd0)      n_sda = n_send[0];
					else if (n_phase == 5'd1) n_scl = 1'b1;
					else                      n_scl = 1'b0;
				end
				default: begin
					if (n_phase == 5'd0)      n_sda = 1'b1;
					else if (n_phase == 5'd1) n_scl = 1'b1;
					else if (n_phase == 5'd2) n_ack = item.sda_in;
					else                      n_scl = 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q  <= '0;
			phase_q <= 5'd0;
			cmd_q   <= OP_START;
			send_q  <= 8'd0;
			rx_q    <= 8'd0;
			scl_q   <= 1'b1;
			sda_q   <= 1'b1;
			run_q   <= 1'b0;
			ack_q   <= 1'b1;
			sub_q   <= SUB_FIRST;
			bit_q   <= 3'd0;
		end else if (step) begin
			tick_q  <= n_tick;
			phase_q <= n_phase;
			cmd_q   <= n_cmd;
			send_q  <= n_send;
			rx_q    <= n_rx;
			scl_q   <= n_scl;
			sda_q   <= n_sda;
			run_q   <= n_run;
			ack_q   <= n_ack;
			sub_q   <= n_sub;
			bit_q   <= n_bit;
		end
	end

	always_comb begin
		result.scl_level = n_scl;
		result.sda_level = n_sda;
		result.busy_res  = n_run;
		result.done_res  = done;
		result.rx_byte   = n_rx;
		result.ack_seen  = n_ack;
	end

endmodule

// ===== hw/rtl/i2c_master_phase_sequencer_core.sv =====
// Open-drain I2C master phase sequencer: one command tick in, one bus drive result out.
// Every transfer on the cmd channel is one bus clock tick; it may start a command (start,
// stop, write byte, read byte, send ack, receive ack) and always carries the sampled SDA
// level. Every tick produces exactly one result transfer with the SCL and SDA drive
// levels (1 = released), busy, a one-tick done pulse when the last phase of a command
// ends, the receive byte and the last sampled ack. A command arriving while busy, on the
// tick done pulses, or with opcode six or seven, is ignored. Each bus phase lasts
// phase_ticks ticks (zero acts as one, values beyond the counter saturate at
// 2^COUNTER_WIDTH-1); write it through the cfg channel only while no tick is in flight.
// Throughput is one tick per clock while results are taken; a tick waits in an input
// register, and the sequencer state update writes the result register as the tick
// leaves it, so a result is offered from the result register after its command has
// passed the input register. A full result register with a stalled consumer holds off
// the input register, and that back-pressure reaches cmd.ready.
module i2c_master_phase_sequencer_core import i2cmps_pkg::*; #(
	parameter int COUNTER_WIDTH = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	i2cmps_cmd_if.sink   cmd,
	i2cmps_cfg_if.sink   cfg,
	i2cmps_res_if.source res
);

	// width wide enough for both the register value and the counter maximum
	localparam int LimW = (COUNTER_WIDTH > 16) ? COUNTER_WIDTH : 16;

	logic [15:0]              phase_ticks_q;
	logic [COUNTER_WIDTH-1:0] lim_q;
	logic [LimW-1:0]          ticks_ext;
	logic [LimW-1:0]          max_ext;
	logic [LimW-1:0]          lim_w;

	cmd_t cmd_s1;
	logic valid_s1;
	res_t res_s2;
	logic valid_s2;
	res_t seq_res;
	cmd_t cmd_in;
	logic s2_free;
	logic s1_go;

	// phase length register; always ready
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_ticks_q <= PHASE_TICKS_RESET;
		end else if (cfg.valid) begin
			phase_ticks_q <= cfg.phase_ticks;
		end
	end

	// effective phase length: zero acts as one, saturate at the counter maximum
	always_comb begin
		ticks_ext = LimW'(phase_ticks_q);
		max_ext   = LimW'({COUNTER_WIDTH{1'b1}});
		if (ticks_ext == '0) begin
			lim_w = LimW'(1);
		end else if (ticks_ext > max_ext) begin
			lim_w = max_ext;
		end else begin
			lim_w = ticks_ext;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lim_q <= '0;
		end else begin
			lim_q <= lim_w[COUNTER_WIDTH-1:0];
		end
	end

	// pipeline handshake: input register feeds the result register
	assign s2_free   = !valid_s2 || res.ready;
	assign s1_go     = valid_s1 && s2_free;
	assign cmd.ready = !valid_s1 || s1_go;

	always_comb begin
		cmd_in.cmd_valid   = cmd.cmd_valid;
		cmd_in.opcode      = cmd.opcode;
		cmd_in.tx_byte     = cmd.tx_byte;
		cmd_in.ack_to_send = cmd.ack_to_send;
		cmd_in.sda_in      = cmd.sda_in;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.ready) begin
			valid_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			cmd_s1 <= cmd_in;
		end
	end

	// sequencer state advances once per tick, when the tick leaves the input register
	i2cmps_seq #(
		.COUNTER_WIDTH (COUNTER_WIDTH)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (s1_go),
		.item      (cmd_s1),
		.phase_lim (lim_q),
		.result    (seq_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_free) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go) begin
			res_s2 <= seq_res;
		end
	end

	assign res.valid     = valid_s2;
	assign res.scl_level = res_s2.scl_level;
	assign res.sda_level = res_s2.sda_level;
	assign res.busy_res  = res_s2.busy_res;
	assign res.done_res  = res_s2.done_res;
	assign res.rx_byte   = res_s2.rx_byte;
	assign res.ack_seen  = res_s2.ack_seen;

endmodule

// ===== hw/rtl/i2cmps_checker.sv =====
// Port-level checks of the I2C phase sequencer, bound to the top level.
`include "i2c_master_phase_sequencer_core_defines.svh"

module i2cmps_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       res_valid,
	input logic       res_ready,
	input logic       scl_level,
	input logic       sda_level,
	input logic       busy_res,
	input logic       done_res,
	input logic [7:0] rx_byte
);

	logic res_xfer;
	logic busy_prev_q;
	logic scl_prev_q;
	logic sda_prev_q;

	assign res_xfer = res_valid && res_ready;

	// status of the previously transferred result; drives idle released after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_prev_q <= 1'b0;
			scl_prev_q  <= 1'b1;
			sda_prev_q  <= 1'b1;
		end else if (res_xfer) begin
			busy_prev_q <= busy_res;
			scl_prev_q  <= scl_level;
			sda_prev_q  <= sda_level;
		end
	end

	// done only ends a running command
	`I2CMPS_ASSERT_NOW(a_done_ends_busy, clk, arst_n, res_xfer && done_res, !busy_res && busy_prev_q)

	// busy only drops with done
	`I2CMPS_ASSERT_NOW(a_drop_has_done, clk, arst_n, res_xfer && busy_prev_q && !busy_res, done_res)

	// bus drives stay put between idle ticks
	`I2CMPS_ASSERT_NOW(a_idle_lines_hold, clk, arst_n, res_xfer && !busy_prev_q && !busy_res, scl_level == scl_prev_q && sda_level == sda_prev_q)

	// stalled result holds
	`I2CMPS_ASSERT_NEXT(a_res_hold, clk, arst_n, res_valid && !res_ready, res_valid && $stable(scl_level) && $stable(rx_byte) && $stable(busy_res))

endmodule

bind i2c_master_phase_sequencer_core i2cmps_checker u_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.res_valid (res.valid),
	.res_ready (res.ready),
	.scl_level (res.scl_level),
	.sda_level (res.sda_level),
	.busy_res  (res.busy_res),
	.done_res  (res.done_res),
	.rx_byte   (res.rx_byte)
);
